// ----- rtl/cbf_pkg.sv -----
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types, constants and helpers for the cubic Bezier flattener.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int COORD_BITS      = 32;
  localparam int MAX_DEPTH       = 6;
  localparam int STACK_SLOTS     = 6;
  localparam int VERTEX_CAPACITY = 4096;
  localparam int CNT_W           = 13;
  localparam int IDX_W           = 12;
  localparam int LEN_W           = 31;
  localparam int SP_W            = 3;
  localparam int LVL_W           = 3;
  localparam int DIST_W          = 37;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_LEN   = 2'd0,
    REG_FLAT_LIM  = 2'd1,
    REG_TRACK_BND = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLAT,
    ST_SPLIT,
    ST_LEN,
    ST_MUL,
    ST_EMIT,
    ST_NEXT,
    ST_LOAD,
    ST_FINISH
  } state_t;

  // One right half waiting on the stack
  typedef struct packed {
    logic [LVL_W-1:0] level;
    coord_t [3:0]     xs;
    coord_t [3:0]     ys;
  } stk_row_t;

  // One result record
  typedef struct packed {
    logic             has;
    coord_t           x;
    coord_t           y;
    logic [IDX_W-1:0] idx;
    logic             ovf;
    coord_t           min_x;
    coord_t           min_y;
    coord_t           max_x;
    coord_t           max_y;
  } vtx_t;

  typedef struct packed {
    logic emit;
    logic finish;
  } out_ctl_t;

  // Floor of the average, exact
  function automatic coord_t mid2(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] s;
    s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    return s[COORD_BITS:1];
  endfunction

endpackage

// ----- rtl/cbf_stack.sv -----
// ----------------------------------------------------------------------------
// cbf_stack
// Row memory for pending right halves; one row write and one read per cycle.
// ----------------------------------------------------------------------------
module cbf_stack
  import cbf_pkg::*;
(
  input  logic            clk,
  input  logic            wr_en,
  input  logic [SP_W-1:0] wr_addr,
  input  stk_row_t        wr_data,
  input  logic            rd_en,
  input  logic [SP_W-1:0] rd_addr,
  output stk_row_t        rd_data
);

  stk_row_t mem [STACK_SLOTS];
  stk_row_t rd_data_r;

  // Write one row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/cbf_out.sv -----
// ----------------------------------------------------------------------------
// cbf_out
// Holds the newest vertex back until the next one or the end of the curve is
// known, so the final item can carry last, and drives the result register.
// ----------------------------------------------------------------------------
module cbf_out
  import cbf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  out_ctl_t         ctl,
  input  vtx_t             vin,
  output logic             ready,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_has_vertex,
  output logic [31:0]      out_vertex_x,
  output logic [31:0]      out_vertex_y,
  output logic [IDX_W-1:0] out_vertex_index,
  output logic             out_index_overflow,
  output logic [31:0]      out_bound_min_x,
  output logic [31:0]      out_bound_min_y,
  output logic [31:0]      out_bound_max_x,
  output logic [31:0]      out_bound_max_y,
  output logic             out_last
);

  logic out_valid_r, out_valid_nxt;
  logic out_last_r, out_last_nxt;
  vtx_t out_r, out_nxt;
  logic pend_v_r, pend_v_nxt;
  vtx_t pend_r, pend_nxt;
  logic free;

  assign free  = !out_valid_r || !out_stall;
  assign ready = free;

  // Move held vertex out on a new one; flush on finish
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_nxt       = out_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    if (ctl.emit && free) begin
      if (pend_v_r) begin
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
      pend_nxt   = vin;
      pend_v_nxt = 1'b1;
    end else if (ctl.finish && free) begin
      out_nxt       = pend_v_r ? pend_r : vin;
      out_last_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
      pend_v_nxt    = 1'b0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    pend_r     <= pend_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_has_vertex     = out_r.has;
  assign out_vertex_x       = out_r.x;
  assign out_vertex_y       = out_r.y;
  assign out_vertex_index   = out_r.idx;
  assign out_index_overflow = out_r.ovf;
  assign out_bound_min_x    = out_r.min_x;
  assign out_bound_min_y    = out_r.min_y;
  assign out_bound_max_x    = out_r.max_x;
  assign out_bound_max_y    = out_r.max_y;
  assign out_last           = out_last_r;

endmodule

// ----- rtl/cubic_bezier_flattener.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Adaptive depth-first flattening of one cubic Bezier curve per item.
// ----------------------------------------------------------------------------
// One curve is worked at a time; in_stall stays high until its last result
// item has been handed to the result register. Each curve node runs up to
// four flatness compares on one shared compare unit, then splits (one axis
// per cycle) or, for a flat piece, takes the chord deltas, squares dx, dy and
// the minimum length on one shared 31x31 multiplier for the length test
// unless a delta already exceeds that length, emits a vertex for a long chord
// and pops the next half from the stack row memory. A fully split curve of
// depth 6 has 63 splits and 64 leaves; the result side can stall the work.
// Results come as one item per emitted vertex, the last one marked; a curve
// that emits nothing gives one item with has_vertex low and last high.
module cubic_bezier_flattener
  import cbf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [30:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_start_x,
  input  logic [31:0]      in_start_y,
  input  logic [31:0]      in_ctrl1_x,
  input  logic [31:0]      in_ctrl1_y,
  input  logic [31:0]      in_ctrl2_x,
  input  logic [31:0]      in_ctrl2_y,
  input  logic [31:0]      in_end_x,
  input  logic [31:0]      in_end_y,
  input  logic             in_new_path,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_has_vertex,
  output logic [31:0]      out_vertex_x,
  output logic [31:0]      out_vertex_y,
  output logic [IDX_W-1:0] out_vertex_index,
  output logic             out_index_overflow,
  output logic [31:0]      out_bound_min_x,
  output logic [31:0]      out_bound_min_y,
  output logic [31:0]      out_bound_max_x,
  output logic [31:0]      out_bound_max_y,
  output logic             out_last
);

  // Configuration
  logic [LEN_W-1:0] min_len_r;
  logic [LEN_W-1:0] flat_lim_r;
  logic             track_r;

  // Control
  state_t            state_r, state_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  coord_t            min_x_r, min_x_nxt, min_y_r, min_y_nxt;
  coord_t            max_x_r, max_x_nxt, max_y_r, max_y_nxt;

  // Current curve and datapath
  coord_t sx_r, sx_nxt, sy_r, sy_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  coord_t bx_r, bx_nxt, by_r, by_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  coord_t [3:0]         rx_r, rx_nxt;
  logic [32:0]          dx_r, dx_nxt, dy_r, dy_nxt;
  logic [2*LEN_W-1:0]   prod_r, prod_nxt;
  logic [2*LEN_W:0]     sum_r, sum_nxt;

  // Shared compare unit
  coord_t                   fc, fp, fq;
  logic signed [DIST_W-1:0] fd, thr3;
  logic                     far;
  logic                     can_split;

  // Split unit
  coord_t s0, s1, s2, s3, p01, p12, p23, p012, p123, pm;

  // Length test
  logic signed [32:0] ddx, ddy;
  logic [LEN_W-1:0]   mop;

  // Emit
  logic             ovf;
  logic [IDX_W-1:0] idx;
  coord_t           nmin_x, nmin_y, nmax_x, nmax_y;

  // Stack and output
  logic            stk_we, stk_re;
  logic [SP_W-1:0] stk_waddr, stk_raddr;
  stk_row_t        stk_wdata, stk_rdata;
  out_ctl_t        octl;
  vtx_t            ovtx;
  logic            out_ready;

  assign in_stall  = (state_r != ST_IDLE);
  assign can_split = (level_r < LVL_W'(MAX_DEPTH)) && (sp_r < SP_W'(STACK_SLOTS));

  // Flatness compare: |c - floor((2p+q)/3)| > L  <=>  d > 3L or d < -3L-2
  always_comb begin
    fc = step_r[1] ? (step_r[0] ? by_r : bx_r) : (step_r[0] ? ay_r : ax_r);
    fp = step_r[1] ? (step_r[0] ? ey_r : ex_r) : (step_r[0] ? sy_r : sx_r);
    fq = step_r[1] ? (step_r[0] ? sy_r : sx_r) : (step_r[0] ? ey_r : ex_r);
    fd = 3 * DIST_W'(fc) - 2 * DIST_W'(fp) - DIST_W'(fq);
    thr3 = 3 * $signed({{(DIST_W-LEN_W){1'b0}}, flat_lim_r});
    far  = (fd > thr3) || (fd < -thr3 - DIST_W'(2));
  end

  // de Casteljau midpoints for one axis
  always_comb begin
    s0   = step_r[0] ? sy_r : sx_r;
    s1   = step_r[0] ? ay_r : ax_r;
    s2   = step_r[0] ? by_r : bx_r;
    s3   = step_r[0] ? ey_r : ex_r;
    p01  = mid2(s0, s1);
    p12  = mid2(s1, s2);
    p23  = mid2(s2, s3);
    p012 = mid2(p01, p12);
    p123 = mid2(p12, p23);
    pm   = mid2(p012, p123);
  end

  // Chord deltas and multiplier operand
  always_comb begin
    ddx = {ex_r[31], ex_r} - {sx_r[31], sx_r};
    ddy = {ey_r[31], ey_r} - {sy_r[31], sy_r};
    unique case (step_r)
      2'd0:    mop = dx_r[LEN_W-1:0];
      2'd1:    mop = dy_r[LEN_W-1:0];
      default: mop = min_len_r;
    endcase
  end

  // Vertex index and widened bounds
  always_comb begin
    ovf    = (cnt_r == CNT_W'(VERTEX_CAPACITY));
    idx    = ovf ? IDX_W'(VERTEX_CAPACITY - 1) : cnt_r[IDX_W-1:0];
    nmin_x = (track_r && ex_r < min_x_r) ? ex_r : min_x_r;
    nmin_y = (track_r && ey_r < min_y_r) ? ey_r : min_y_r;
    nmax_x = (track_r && ex_r > max_x_r) ? ex_r : max_x_r;
    nmax_y = (track_r && ey_r > max_y_r) ? ey_r : max_y_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    level_nxt = level_r;
    sp_nxt    = sp_r;
    cnt_nxt   = cnt_r;
    min_x_nxt = min_x_r;
    min_y_nxt = min_y_r;
    max_x_nxt = max_x_r;
    max_y_nxt = max_y_r;
    sx_nxt = sx_r; sy_nxt = sy_r; ax_nxt = ax_r; ay_nxt = ay_r;
    bx_nxt = bx_r; by_nxt = by_r; ex_nxt = ex_r; ey_nxt = ey_r;
    rx_nxt   = rx_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    prod_nxt = prod_r;
    sum_nxt  = sum_r;
    stk_we    = 1'b0;
    stk_waddr = sp_r;
    stk_wdata = '{level: level_r + LVL_W'(1), xs: rx_r, ys: {ey_r, p23, p123, pm}};
    stk_re    = 1'b0;
    stk_raddr = sp_r - SP_W'(1);
    octl      = '{emit: 1'b0, finish: 1'b0};
    ovtx      = '{has: 1'b1, x: ex_r, y: ey_r, idx: idx, ovf: ovf,
                  min_x: nmin_x, min_y: nmin_y, max_x: nmax_x, max_y: nmax_y};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sx_nxt = in_start_x; sy_nxt = in_start_y;
          ax_nxt = in_ctrl1_x; ay_nxt = in_ctrl1_y;
          bx_nxt = in_ctrl2_x; by_nxt = in_ctrl2_y;
          ex_nxt = in_end_x;   ey_nxt = in_end_y;
          level_nxt = '0;
          sp_nxt    = '0;
          step_nxt  = '0;
          if (in_new_path) begin
            cnt_nxt   = '0;
            min_x_nxt = COORD_MAX;
            min_y_nxt = COORD_MAX;
            max_x_nxt = COORD_MIN;
            max_y_nxt = COORD_MIN;
          end
          state_nxt = ST_FLAT;
        end
      end

      // One control-point compare per cycle
      ST_FLAT: begin
        if (!can_split) begin
          state_nxt = ST_LEN;
        end else if (far) begin
          step_nxt  = '0;
          state_nxt = ST_SPLIT;
        end else if (step_r == 2'd3) begin
          state_nxt = ST_LEN;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end

      // x axis first, then y axis with the push
      ST_SPLIT: begin
        if (step_r[0] == 1'b0) begin
          rx_nxt = {ex_r, p23, p123, pm};
          ax_nxt = p01; bx_nxt = p012; ex_nxt = pm;
          step_nxt = 2'd1;
        end else begin
          stk_we    = 1'b1;
          ay_nxt = p01; by_nxt = p012; ey_nxt = pm;
          level_nxt = level_r + LVL_W'(1);
          sp_nxt    = sp_r + SP_W'(1);
          step_nxt  = '0;
          state_nxt = ST_FLAT;
        end
      end

      ST_LEN: begin
        dx_nxt    = ddx[32] ? 33'(-ddx) : 33'(ddx);
        dy_nxt    = ddy[32] ? 33'(-ddy) : 33'(ddy);
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end

      // Shared multiplier: dx^2, dy^2, min^2, compare; skipped if a delta > min
      ST_MUL: begin
        if ((dx_r > {2'b00, min_len_r}) || (dy_r > {2'b00, min_len_r})) begin
          state_nxt = ST_EMIT;
        end else begin
          prod_nxt = mop * mop;
          unique case (step_r)
            2'd0: step_nxt = 2'd1;
            2'd1: begin
              sum_nxt  = {1'b0, prod_r};
              step_nxt = 2'd2;
            end
            2'd2: begin
              sum_nxt  = sum_r + {1'b0, prod_r};
              step_nxt = 2'd3;
            end
            default: begin
              state_nxt = (sum_r > {1'b0, prod_r}) ? ST_EMIT : ST_NEXT;
            end
          endcase
        end
      end

      ST_EMIT: begin
        octl.emit = 1'b1;
        if (out_ready) begin
          if (!ovf) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          min_x_nxt = nmin_x;
          min_y_nxt = nmin_y;
          max_x_nxt = nmax_x;
          max_y_nxt = nmax_y;
          state_nxt = ST_NEXT;
        end
      end

      // Pop the next right half or finish the curve
      ST_NEXT: begin
        if (sp_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          stk_re    = 1'b1;
          sp_nxt    = sp_r - SP_W'(1);
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        sx_nxt = stk_rdata.xs[0]; ax_nxt = stk_rdata.xs[1];
        bx_nxt = stk_rdata.xs[2]; ex_nxt = stk_rdata.xs[3];
        sy_nxt = stk_rdata.ys[0]; ay_nxt = stk_rdata.ys[1];
        by_nxt = stk_rdata.ys[2]; ey_nxt = stk_rdata.ys[3];
        level_nxt = stk_rdata.level;
        step_nxt  = '0;
        state_nxt = ST_FLAT;
      end

      ST_FINISH: begin
        octl.finish = 1'b1;
        ovtx = '{has: 1'b0, x: '0, y: '0, idx: '0, ovf: 1'b0,
                 min_x: min_x_r, min_y: min_y_r, max_x: max_x_r, max_y: max_y_r};
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      level_r <= '0;
      sp_r    <= '0;
      cnt_r   <= '0;
      min_x_r <= COORD_MAX;
      min_y_r <= COORD_MAX;
      max_x_r <= COORD_MIN;
      max_y_r <= COORD_MIN;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      level_r <= level_nxt;
      sp_r    <= sp_nxt;
      cnt_r   <= cnt_nxt;
      min_x_r <= min_x_nxt;
      min_y_r <= min_y_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
    end
  end

  // Curve and datapath registers
  always_ff @(posedge clk) begin
    sx_r <= sx_nxt; sy_r <= sy_nxt; ax_r <= ax_nxt; ay_r <= ay_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    rx_r   <= rx_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r  <= '0;
      flat_lim_r <= LEN_W'(32768);
      track_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_LEN:   min_len_r  <= cfg_data;
        REG_FLAT_LIM:  flat_lim_r <= cfg_data;
        REG_TRACK_BND: track_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cbf_stack u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  cbf_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (octl),
    .vin                (ovtx),
    .ready              (out_ready),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_has_vertex     (out_has_vertex),
    .out_vertex_x       (out_vertex_x),
    .out_vertex_y       (out_vertex_y),
    .out_vertex_index   (out_vertex_index),
    .out_index_overflow (out_index_overflow),
    .out_bound_min_x    (out_bound_min_x),
    .out_bound_min_y    (out_bound_min_y),
    .out_bound_max_x    (out_bound_max_x),
    .out_bound_max_y    (out_bound_max_y),
    .out_last           (out_last)
  );

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the cubic Bezier flattener: drives curves, predicts vertices.
// ----------------------------------------------------------------------------
// A behavioral predictor runs the depth-first subdivision on 64-bit signed
// values and queues the expected result items for each accepted curve. A
// checker process compares every accepted result item field by field with
// the oldest queued item. Both sides idle at random, and registers are
// rewritten between phases while the block is idle.
module tb_top
  import cbf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        has;
    logic [31:0] x, y;
    logic [11:0] idx;
    logic        ovf;
    logic [31:0] mnx, mny, mxx, mxy;
    logic        lst;
  } vertex_rec_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_MIN_LEN;
  logic [30:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [31:0] in_start_x = 0, in_start_y = 0, in_ctrl1_x = 0, in_ctrl1_y = 0;
  logic [31:0] in_ctrl2_x = 0, in_ctrl2_y = 0, in_end_x = 0, in_end_y = 0;
  logic in_new_path = 0;
  logic out_valid, out_stall = 1;
  logic out_has_vertex, out_index_overflow, out_last;
  logic [31:0] out_vertex_x, out_vertex_y;
  logic [11:0] out_vertex_index;
  logic [31:0] out_bound_min_x, out_bound_min_y, out_bound_max_x, out_bound_max_y;

  cubic_bezier_flattener uut (.*);

  always #5 clk = ~clk;

  // predictor state
  longint min_len = 0, flat_lim = 32768;
  bit     bnd_on = 1;
  int     vcount = 0;
  longint lo_b[2], hi_b[2];
  vertex_rec_t vertex_q[$];
  int errors = 0, n_results = 0, n_vertices = 0, n_items = 0;
  bit hold_off = 0;

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit too_curved(longint c[8]);
    longint t1, t2;
    for (int a = 0; a < 2; a++) begin
      t1 = fdiv(2 * c[a] + c[6+a], 3);
      t2 = fdiv(c[a] + 2 * c[6+a], 3);
      if (absv(c[2+a] - t1) > flat_lim || absv(c[4+a] - t2) > flat_lim) return 1;
    end
    return 0;
  endfunction

  function automatic bit chord_long(longint c[8]);
    longint unsigned dx, dy, m;
    dx = absv(c[6] - c[0]);
    dy = absv(c[7] - c[1]);
    m = min_len;
    if (dx > m || dy > m) return 1;
    return dx * dx + dy * dy > m * m;
  endfunction

  function automatic void reset_path();
    vcount = 0;
    lo_b[0] = 64'sd2147483647; lo_b[1] = 64'sd2147483647;
    hi_b[0] = -64'sd2147483648; hi_b[1] = -64'sd2147483648;
  endfunction

  function automatic vertex_rec_t make_rec(bit h, longint x, longint y, int i, bit o);
    vertex_rec_t r;
    r.has = h; r.x = x[31:0]; r.y = y[31:0]; r.idx = i[11:0]; r.ovf = o;
    r.mnx = lo_b[0][31:0]; r.mny = lo_b[1][31:0];
    r.mxx = hi_b[0][31:0]; r.mxy = hi_b[1][31:0]; r.lst = 0;
    return r;
  endfunction

  // Flatten one curve and queue its vertices.
  function automatic void flatten_curve(logic [31:0] p[8], bit np);
    longint cur[8], stk[6][8], m, p01, p12, p23, p012, p123;
    int lvls[6];
    int sp, lvl, cnt, idx;
    bit ovf;
    if (np) reset_path();
    foreach (cur[i]) cur[i] = longint'($signed(p[i]));
    sp = 0; lvl = 0; cnt = 0;
    forever begin
      if (lvl < MAX_DEPTH && sp < STACK_SLOTS && too_curved(cur)) begin
        for (int i = 0; i < 2; i++) begin
          p01 = fdiv(cur[i] + cur[2+i], 2);
          p12 = fdiv(cur[2+i] + cur[4+i], 2);
          p23 = fdiv(cur[4+i] + cur[6+i], 2);
          p012 = fdiv(p01 + p12, 2);
          p123 = fdiv(p12 + p23, 2);
          m = fdiv(p012 + p123, 2);
          stk[sp][i] = m; stk[sp][2+i] = p123; stk[sp][4+i] = p23;
          stk[sp][6+i] = cur[6+i];
          cur[2+i] = p01; cur[4+i] = p012; cur[6+i] = m;
        end
        lvl++;
        lvls[sp] = lvl;
        sp++;
        continue;
      end
      if (chord_long(cur) && cnt < 64) begin
        ovf = vcount >= VERTEX_CAPACITY;
        idx = ovf ? VERTEX_CAPACITY - 1 : vcount;
        if (!ovf) vcount++;
        if (bnd_on) begin
          if (cur[6] < lo_b[0]) lo_b[0] = cur[6];
          if (cur[7] < lo_b[1]) lo_b[1] = cur[7];
          if (cur[6] > hi_b[0]) hi_b[0] = cur[6];
          if (cur[7] > hi_b[1]) hi_b[1] = cur[7];
        end
        vertex_q.push_back(make_rec(1, cur[6], cur[7], idx, ovf));
        cnt++;
      end
      if (sp == 0) break;
      sp--;
      cur = stk[sp];
      lvl = lvls[sp];
    end
    if (cnt == 0) vertex_q.push_back(make_rec(0, 0, 0, 0, 0));
    vertex_q[$].lst = 1;
  endfunction

  // Drive one curve; predict at acceptance.
  task automatic send_curve(logic [31:0] p[8], bit np, bit gaps = 1);
    if (gaps) repeat ($urandom_range(0, 6)) @(negedge clk);
    in_start_x <= p[0]; in_start_y <= p[1]; in_ctrl1_x <= p[2]; in_ctrl1_y <= p[3];
    in_ctrl2_x <= p[4]; in_ctrl2_y <= p[5]; in_end_x <= p[6]; in_end_y <= p[7];
    in_new_path <= np;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    flatten_curve(p, np);
    n_items++;
    @(negedge clk);
    in_valid <= 0;
    // let the drop settle; the block is busy with this curve anyway
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (vertex_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    // latency for trailing work with no result pending
    repeat (1000) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (r)
      REG_MIN_LEN:   min_len = v;
      REG_FLAT_LIM:  flat_lim = v;
      REG_TRACK_BND: bnd_on = v[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
    endcase
  endfunction

  task automatic send_random(int mode, bit gaps = 1);
    logic [31:0] p[8];
    foreach (p[i]) p[i] = rnd_coord(mode);
    send_curve(p, $urandom_range(0, 9) == 0, gaps);
  endtask

  // Directed extremes: corners, straight lines, degenerate points.
  task automatic test_directed();
    logic [31:0] p[8];
    p = '{default: 32'h0}; send_curve(p, 1);
    p = '{default: 32'h7fff_ffff}; send_curve(p, 0);
    p = '{default: 32'h8000_0000}; send_curve(p, 0);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    send_curve(p, 1);
    p = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    send_curve(p, 0);
    p = '{0, 0, 32'h0001_0000, 0, 32'h0002_0000, 0, 32'h0003_0000, 0};
    send_curve(p, 0);
    p = '{0, 0, 32'h0100_0000, 32'h0200_0000, 32'hff00_0000, 32'h0200_0000,
          0, 0};
    send_curve(p, 1);
    p = '{32'hffff_ffff, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa,
          32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001, 32'hffff_ffff};
    send_curve(p, 0);
    for (int i = 0; i < 6; i++) send_random(i % 3);
    drain();
  endtask

  // Register sweep including extremes.
  task automatic test_registers();
    write_reg(REG_FLAT_LIM, '0);
    write_reg(REG_MIN_LEN, 31'h7fff_ffff);
    repeat (6) send_random(1);
    drain();
    write_reg(REG_MIN_LEN, 31'h0001_0000);
    write_reg(REG_TRACK_BND, 31'd0);
    repeat (6) send_random(1);
    drain();
    write_reg(REG_FLAT_LIM, 31'h7fff_ffff);
    write_reg(REG_TRACK_BND, 31'd1);
    write_reg(REG_MIN_LEN, '0);
    repeat (6) send_random(0);
    drain();
  endtask

  // Deep subdivision to push the vertex index past capacity.
  task automatic test_overflow();
    logic [31:0] p[8];
    write_reg(REG_FLAT_LIM, '0);
    p = '{0, 0, 32'h4000_0000, 32'h4000_0000, 32'hc000_0000, 32'h4000_0000,
          32'h0000_1000, 0};
    send_curve(p, 1, 0);
    repeat (66) send_curve(p, 0, 0);
    drain();
    write_reg(REG_FLAT_LIM, 31'h0000_8000);
  endtask

  // Long receiver hold-off while curves keep coming; then a full pause.
  task automatic test_backpressure();
    hold_off = 1;
    repeat (4) send_random(1, 0);
    hold_off = 0;
    drain();
  endtask

  task automatic test_random();
    int seg;
    for (int k = 0; k < 108; k++) begin
      if (k % 36 == 0) begin
        drain();
        seg = k / 36;
        write_reg(REG_FLAT_LIM,
                  seg == 0 ? 31'h0000_8000 : 31'($urandom_range(0, 32'h0008_0000)));
        write_reg(REG_MIN_LEN, 31'($urandom_range(0, 32'h0004_0000)));
        write_reg(REG_TRACK_BND, 31'($urandom_range(0, 1)));
      end
      send_random($urandom_range(0, 2), k % 36 < 27);
    end
    drain();
  endtask

  // Receiver: random wait before each item, a long hold-off on request.
  initial begin
    int hold, wait_cycles;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        for (hold = 0; hold < 2000; hold++) @(negedge clk);
        hold_off = 0;
      end
      wait_cycles = $urandom_range(0, 6);
      if (wait_cycles > 0) begin
        out_stall <= 1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Checker: compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    vertex_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected result item x=%h y=%h", $time, out_vertex_x, out_vertex_y);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (e.has) n_vertices++;
        if ({out_has_vertex, out_vertex_x, out_vertex_y, out_vertex_index,
             out_index_overflow, out_bound_min_x, out_bound_min_y, out_bound_max_x,
             out_bound_max_y, out_last} !==
            {e.has, e.x, e.y, e.idx, e.ovf, e.mnx, e.mny, e.mxx, e.mxy, e.lst}) begin
          errors++;
          $display("%0t: mismatch exp has=%b x=%h y=%h idx=%0d ovf=%b min=%h,%h max=%h,%h last=%b",
                   $time, e.has, e.x, e.y, e.idx, e.ovf, e.mnx, e.mny, e.mxx, e.mxy, e.lst);
          $display("%0t:          got has=%b x=%h y=%h idx=%0d ovf=%b min=%h,%h max=%h,%h last=%b",
                   $time, out_has_vertex, out_vertex_x, out_vertex_y, out_vertex_index,
                   out_index_overflow, out_bound_min_x, out_bound_min_y,
                   out_bound_max_x, out_bound_max_y, out_last);
        end
      end
    end
  end

  initial begin
    reset_path();
    repeat (11) @(negedge clk);
    rst_n <= 1;
    test_directed();
    test_registers();
    test_overflow();
    test_backpressure();
    test_random();
    if (vertex_q.size() != 0) begin
      $display("%0d expected result items never arrived", vertex_q.size());
      errors++;
    end
    $display("Sent %0d curves; checked %0d result items carrying %0d vertices.",
             n_items, n_results, n_vertices);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
